// File: rtl/core/tabular_q_learning_agent_defines.svh
// ---------------------------------------------------------------------------
// tabular_q_learning_agent_defines.svh
// Assertion macros used by the Q-learning agent checker.
// ---------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_AGENT_DEFINES_SVH
`define TABULAR_Q_LEARNING_AGENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TQLA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tqla: implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TQLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tqla: next-cycle check failed");

`endif

// File: rtl/core/tqla_pkg.sv
// ---------------------------------------------------------------------------
// tqla_pkg
// Types, constants and row helpers for the tabular Q-learning agent.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tqla_pkg;

  // Geometry
  localparam int Q_W      = 32;
  localparam int NUM_ACT  = 3;
  localparam int ROW_W    = NUM_ACT * Q_W;
  localparam int COEF_W   = 17;

  localparam int STATE_BITS_DEF  = 12;
  localparam int Q_FRAC_BITS_DEF = 16;

  // Q1.16 constants
  localparam logic [COEF_W-1:0] ONE_Q016       = 17'd65536;
  localparam logic [COEF_W-1:0] LEARN_RATE_RST = 17'd6554;
  localparam logic [COEF_W-1:0] DISCOUNT_RST   = 17'd58982;

  // Rounding of Q1.16 products: add half, shift by 16
  localparam int RND_HALF  = 32768;
  localparam int RND_SHIFT = 16;

  // Decay: rate * 0.9995 floored == rate - ceil(rate / 2000).
  // ceil(rate / 2000) = ((rate + 1999) * DEC_RECIP) >> DEC_SHIFT, exact for
  // every 17-bit operand.
  localparam int DEC_BIAS  = 1999;
  localparam int DEC_RECIP = 134218;
  localparam int DEC_SHIFT = 28;
  localparam int DEC_Q_W   = 6;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  // Operation codes
  localparam logic [1:0] FUNC_CHOOSE = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_DECAY  = 2'd2;

  // Action codes
  localparam logic [1:0] ACT_LEFT  = 2'd0;
  localparam logic [1:0] ACT_STAY  = 2'd1;
  localparam logic [1:0] ACT_RIGHT = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // Config register indexes
  localparam logic CFG_LEARN_RATE = 1'b0;
  localparam logic CFG_DISCOUNT   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_S,
    ST_READ_NS,
    ST_CHOOSE,
    ST_MAX,
    ST_MUL_G,
    ST_TARGET,
    ST_DELTA,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_WRITE,
    ST_DEC_MUL,
    ST_DEC_SUB,
    ST_FINISH
  } state_t;

  function automatic logic signed [Q_W-1:0] row_field(input logic [ROW_W-1:0] row,
                                                      input logic [1:0] act);
    logic signed [Q_W-1:0] v;
    case (act)
      ACT_LEFT:  v = row[0*Q_W +: Q_W];
      ACT_STAY:  v = row[1*Q_W +: Q_W];
      ACT_RIGHT: v = row[2*Q_W +: Q_W];
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] row_put(input logic [ROW_W-1:0] row,
                                               input logic [1:0] act,
                                               input logic signed [Q_W-1:0] v);
    logic [ROW_W-1:0] r;
    r = row;
    case (act)
      ACT_LEFT:  r[0*Q_W +: Q_W] = v;
      ACT_STAY:  r[1*Q_W +: Q_W] = v;
      ACT_RIGHT: r[2*Q_W +: Q_W] = v;
      default:   r = row;
    endcase
    return r;
  endfunction

  // Argmax over one row, ties to the lower action
  function automatic logic [1:0] best_act(input logic [ROW_W-1:0] row);
    logic signed [Q_W-1:0] bq;
    logic [1:0]            b;
    b  = ACT_LEFT;
    bq = row_field(row, ACT_LEFT);
    if (row_field(row, ACT_STAY) > bq) begin
      b  = ACT_STAY;
      bq = row_field(row, ACT_STAY);
    end
    if (row_field(row, ACT_RIGHT) > bq) begin
      b = ACT_RIGHT;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tabular_q_learning_agent.sv
// Sequencing: one transaction at a time; in_ready is high only while idle, so a new
//   transaction is taken only once the last result has gone to the output register,
//   and a stalled output register holds the sequencer until it is free. The Q-table RAM
//   has a single read port and all arithmetic shares the one multiplier.
// Reset: synchronous; afterwards the table is zeroed row by row, with in_ready low;
//   config writes are taken meanwhile.
// ---------------------------------------------------------------------------
// tabular_q_learning_agent
// Tabular Q-learning engine, three actions per state, epsilon-greedy choice,
// Q16.16 update with saturation and epsilon decay, all on one multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tabular_q_learning_agent
  import tqla_pkg::*;
#(
  parameter int STATE_BITS  = STATE_BITS_DEF,
  parameter int Q_FRAC_BITS = Q_FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,

  // config write port
  input  wire logic                   cfg_write,
  input  wire logic                   cfg_index,
  input  wire logic [COEF_W-1:0]      cfg_data,

  // input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             func,
  input  wire logic [STATE_BITS-1:0]  state_index,
  input  wire logic [1:0]             action_taken,
  input  wire logic signed [15:0]     reward,
  input  wire logic [STATE_BITS-1:0]  next_state_index,
  input  wire logic [15:0]            explore_draw,
  input  wire logic [1:0]             random_action,

  // output channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  chosen_action,
  output logic                        explored,
  output logic signed [Q_W-1:0]       q_value,
  output logic [COEF_W-1:0]           epsilon_now
);

  // -------------------------------------------------------------------------
  // Datapath widths; RW and the widths built from it follow Q_FRAC_BITS.
  //   RW: reward << Q_FRAC_BITS          TW: target = scaled reward + gamma*maxQ
  //   DW: delta = target - Q(s,a)        HW: delta without its low 16 bits
  //   MW: wide multiplier operand        PW: multiplier product
  //   NW: new Q before saturation
  // -------------------------------------------------------------------------
  localparam int RW    = 16 + Q_FRAC_BITS;
  localparam int TW    = ((RW > Q_W) ? RW : Q_W) + 1;
  localparam int DW    = TW + 1;
  localparam int HW    = DW - RND_SHIFT;
  localparam int MW    = (HW > Q_W) ? HW : Q_W;
  localparam int PW    = MW + COEF_W + 1;
  localparam int NW    = DW + 2;
  localparam int GR_W  = Q_W + 1;         // rounded gamma*maxQ
  localparam int LO_W  = 2 * RND_SHIFT + 2; // alpha times the low delta bits
  localparam int LR_W  = COEF_W;          // rounded low partial product
  localparam int DEPTH = 1 << STATE_BITS;

  // -------------------------------------------------------------------------
  // Sequencer state
  // -------------------------------------------------------------------------
  state_t                  state;
  state_t                  state_next;
  logic [STATE_BITS-1:0]   clr_cnt;

  // Config and epsilon
  logic [COEF_W-1:0]       learn_rate;
  logic [COEF_W-1:0]       discount;
  logic [COEF_W-1:0]       explore_rate;

  // Transaction captured at the input handshake
  logic [1:0]              func_q;
  logic [STATE_BITS-1:0]   s_q;
  logic [STATE_BITS-1:0]   ns_q;
  logic [1:0]              act_q;
  logic signed [15:0]      r_q;
  logic [15:0]             draw_q;
  logic [1:0]              ract_q;

  // Q-table RAM: one row of three Q values per state
  logic [ROW_W-1:0]        q_mem [DEPTH];
  logic [ROW_W-1:0]        rd_row;
  logic                    mem_we;
  logic [STATE_BITS-1:0]   mem_raddr;
  logic [STATE_BITS-1:0]   mem_waddr;
  logic [ROW_W-1:0]        mem_wdata;

  // Working registers
  logic [ROW_W-1:0]        row_cur;
  logic signed [Q_W-1:0]   maxn;
  logic signed [TW-1:0]    tgt;
  logic signed [DW-1:0]    delta;
  logic [LR_W-1:0]         lo_rnd;
  logic signed [PW-1:0]    mul_p;

  // Result being built for this transaction
  logic [1:0]              res_action;
  logic                    res_explored;
  logic signed [Q_W-1:0]   res_q;

  // Combinational datapath
  logic                    load_out;
  logic [COEF_W-1:0]       alpha_c;
  logic [COEF_W-1:0]       gamma_c;
  logic signed [COEF_W:0]  mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [TW-1:0]    rs_scaled;
  logic signed [PW-1:0]    g_sum;
  logic signed [GR_W-1:0]  g_rnd;
  logic [LO_W-1:0]         lo_sum;
  logic signed [HW-1:0]    hi_part;
  logic signed [NW-1:0]    hi_term;
  logic signed [Q_W-1:0]   cur_q;
  logic signed [NW-1:0]    nq;
  logic signed [Q_W-1:0]   sat_q;
  logic [1:0]              best_b;
  logic [COEF_W-1:0]       dec_y;
  logic [DEC_Q_W-1:0]      dec_q;

  // -------------------------------------------------------------------------
  // Sequencer: next state and control strobes
  // -------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        // zero one row per cycle until the last one is written
        mem_we = 1'b1;
        if (clr_cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func)
            FUNC_CHOOSE: state_next = ST_READ_S;
            FUNC_UPDATE: begin
              // update with no real action: nothing to do, zero result
              state_next = (action_taken == ACT_NONE) ? ST_FINISH : ST_READ_S;
            end
            FUNC_DECAY:  state_next = ST_DEC_MUL;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_READ_S:  state_next = (func_q == FUNC_CHOOSE) ? ST_CHOOSE : ST_READ_NS;
      ST_CHOOSE:  state_next = ST_FINISH;
      ST_READ_NS: state_next = ST_MAX;
      ST_MAX:     state_next = ST_MUL_G;
      ST_MUL_G:   state_next = ST_TARGET;
      ST_TARGET:  state_next = ST_DELTA;
      ST_DELTA:   state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_WRITE;
      ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = ST_FINISH;
      end
      ST_DEC_MUL: state_next = ST_DEC_SUB;
      ST_DEC_SUB: state_next = ST_FINISH;
      ST_FINISH: begin
        // hand the result to the output register once it is free
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // RAM addressing. Reads: row s, then row s' for an update.
  // Writes: the clearing pass, or the updated row s.
  // -------------------------------------------------------------------------
  always_comb begin
    mem_raddr = (state == ST_READ_NS) ? ns_q : s_q;
    mem_waddr = (state == ST_CLEAR) ? clr_cnt : s_q;
    mem_wdata = (state == ST_CLEAR) ? '0 : row_put(row_cur, act_q, sat_q);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      q_mem[mem_waddr] <= mem_wdata;
    end
    rd_row <= q_mem[mem_raddr];
  end

  // -------------------------------------------------------------------------
  // Shared multiplier: an 18-bit signed coefficient times a wide signed word,
  // product registered every cycle.
  //   MUL_G  : gamma * maxQ(s')
  //   MUL_LO : alpha * delta[15:0]      (unsigned low half)
  //   MUL_HI : alpha * (delta >>> 16)   (signed high part)
  //   DEC_MUL: (rate + 1999) * reciprocal of 2000
  // -------------------------------------------------------------------------
  assign alpha_c = (learn_rate > ONE_Q016) ? ONE_Q016 : learn_rate;
  assign gamma_c = (discount > ONE_Q016) ? ONE_Q016 : discount;
  assign hi_part = delta[DW-1:RND_SHIFT];
  assign dec_y   = explore_rate + COEF_W'(DEC_BIAS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_G: begin
        mul_a = $signed({1'b0, gamma_c});
        mul_b = MW'(maxn);
      end
      ST_MUL_LO: begin
        mul_a = $signed({1'b0, alpha_c});
        mul_b = $signed(MW'(delta[RND_SHIFT-1:0]));
      end
      ST_MUL_HI: begin
        mul_a = $signed({1'b0, alpha_c});
        mul_b = MW'(hi_part);
      end
      ST_DEC_MUL: begin
        mul_a = $signed({1'b0, dec_y});
        mul_b = MW'(DEC_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Arithmetic around the multiplier. Rounding is floor((x + 2^15) / 2^16).
  // alpha*delta is split so that
  //   round(alpha*delta) = alpha*(delta >>> 16) + round(alpha*delta[15:0]).
  // -------------------------------------------------------------------------
  assign rs_scaled = TW'(r_q) <<< Q_FRAC_BITS;
  assign g_sum     = mul_p + PW'(RND_HALF);
  assign g_rnd     = g_sum[RND_SHIFT +: GR_W];
  assign lo_sum    = mul_p[LO_W-1:0] + LO_W'(RND_HALF);
  assign hi_term   = mul_p[NW-1:0];
  assign cur_q     = row_field(row_cur, act_q);
  assign nq        = NW'(cur_q) + hi_term + $signed(NW'(lo_rnd));
  assign best_b    = best_act(rd_row);
  assign dec_q     = mul_p[DEC_SHIFT +: DEC_Q_W];

  always_comb begin
    if (nq > NW'(Q_MAX)) begin
      sat_q = Q_MAX;
    end else if (nq < NW'(Q_MIN)) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = nq[Q_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      learn_rate   <= LEARN_RATE_RST;
      discount     <= DISCOUNT_RST;
      explore_rate <= ONE_Q016;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_LEARN_RATE: learn_rate <= cfg_data;
          CFG_DISCOUNT:   discount   <= cfg_data;
          default:        learn_rate <= learn_rate;
        endcase
      end
      // epsilon drops by ceil(rate / 2000), never below zero
      if (state == ST_DEC_SUB) begin
        explore_rate <= explore_rate - COEF_W'(dec_q);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;

    if (in_valid && in_ready) begin
      func_q       <= func;
      s_q          <= state_index;
      ns_q         <= next_state_index;
      act_q        <= action_taken;
      r_q          <= reward;
      draw_q       <= explore_draw;
      ract_q       <= random_action;
      res_action   <= ACT_LEFT;
      res_explored <= 1'b0;
      res_q        <= '0;
    end

    case (state)
      ST_CHOOSE: begin
        // best Q is reported even when exploring
        res_q <= row_field(rd_row, best_b);
        if ({1'b0, draw_q} < explore_rate) begin
          // random action three folds to action zero
          res_action   <= (ract_q == ACT_NONE) ? ACT_LEFT : ract_q;
          res_explored <= 1'b1;
        end else begin
          res_action <= best_b;
        end
      end
      ST_READ_NS: row_cur <= rd_row;
      ST_MAX:     maxn    <= row_field(rd_row, best_b);
      ST_TARGET:  tgt     <= rs_scaled + TW'(g_rnd);
      ST_DELTA:   delta   <= DW'(tgt) - DW'(cur_q);
      ST_MUL_HI:  lo_rnd  <= lo_sum[RND_SHIFT +: LR_W];
      ST_WRITE:   res_q   <= sat_q;
      default: ;
    endcase

    if (load_out) begin
      chosen_action <= res_action;
      explored      <= res_explored;
      q_value       <= res_q;
      epsilon_now   <= explore_rate;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tqla_checker.sv
// ---------------------------------------------------------------------------
// tqla_checker
// Port-level checks for the Q-learning agent, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tabular_q_learning_agent_defines.svh"

module tqla_checker
  import tqla_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [1:0]              chosen_action,
  input wire logic                    explored,
  input wire logic signed [Q_W-1:0]   q_value,
  input wire logic [COEF_W-1:0]       epsilon_now
);

  // epsilon of the last delivered result; it only ever decays
  logic [COEF_W-1:0] last_eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_eps <= ONE_Q016;
    end else if (out_valid && out_ready) begin
      last_eps <= epsilon_now;
    end
  end

  `TQLA_ASSERT_IMPL(a_eps_monotone, out_valid, epsilon_now <= last_eps)

  `TQLA_ASSERT_IMPL(a_action_legal, out_valid, chosen_action != ACT_NONE)

  `TQLA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  `TQLA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(q_value) && $stable(epsilon_now) &&
                    $stable(chosen_action) && $stable(explored))

endmodule

bind tabular_q_learning_agent tqla_checker u_tqla_checker (.*);

`default_nettype wire

// File: verif/tabular_q_learning_agent_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tabular_q_learning_agent_check
// Follows config writes and both channels. Keeps its own Q table, rate and
// coefficients, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------

module tabular_q_learning_agent_check
  import tqla_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [COEF_W-1:0]         cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                func,
  input  logic [STATE_BITS_DEF-1:0] state_index,
  input  logic [1:0]                action_taken,
  input  logic signed [15:0]        reward,
  input  logic [STATE_BITS_DEF-1:0] next_state_index,
  input  logic [15:0]               explore_draw,
  input  logic [1:0]                random_action,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [1:0]                chosen_action,
  input  logic                      explored,
  input  logic signed [Q_W-1:0]     q_value,
  input  logic [COEF_W-1:0]         epsilon_now,
  output int                        mismatches,
  output int                        pending
);

  localparam int     ENTRIES   = NUM_ACT * (1 << STATE_BITS_DEF);
  localparam longint DECAY_NUM = 9995;
  localparam longint DECAY_DEN = 10000;

  typedef struct {
    logic [1:0]            act;
    logic                  expl;
    logic signed [Q_W-1:0] q;
    logic [COEF_W-1:0]     eps;
  } outcome_t;

  logic signed [Q_W-1:0] q_mem [ENTRIES];
  logic [COEF_W-1:0]     eps_rate;
  logic [COEF_W-1:0]     alpha;
  logic [COEF_W-1:0]     gamma;
  outcome_t              awaited_outcomes [$];
  int                    err_count = 0;
  int                    result_count = 0;

  // Q1.16 product back to integer scale: round half up (floor of x + 0.5)
  function automatic longint round_frac(input longint x);
    longint y;
    y = x + RND_HALF;
    return y >>> RND_SHIFT;
  endfunction

  function automatic logic [COEF_W-1:0] unit_clamp(input logic [COEF_W-1:0] v);
    return (v > ONE_Q016) ? ONE_Q016 : v;
  endfunction

  // argmax over one row, ties to the lower action
  function automatic logic [1:0] greedy(input int s, output logic signed [Q_W-1:0] best);
    logic [1:0] b;
    b    = ACT_LEFT;
    best = q_mem[s*NUM_ACT];
    if (q_mem[s*NUM_ACT+1] > best) begin
      b    = ACT_STAY;
      best = q_mem[s*NUM_ACT+1];
    end
    if (q_mem[s*NUM_ACT+2] > best) begin
      b    = ACT_RIGHT;
      best = q_mem[s*NUM_ACT+2];
    end
    return b;
  endfunction

  function automatic outcome_t apply_transaction(input logic [1:0] fn, input int s,
                                                 input logic [1:0] a,
                                                 input logic signed [15:0] r, input int ns,
                                                 input logic [15:0] draw,
                                                 input logic [1:0] ract);
    outcome_t              o;
    logic signed [Q_W-1:0] best;
    logic [1:0]            b;
    longint                cur;
    longint                target;
    longint                nq;
    int                    idx;
    o.act  = ACT_LEFT;
    o.expl = 1'b0;
    o.q    = '0;
    case (fn)
      FUNC_CHOOSE: begin
        b   = greedy(s, best);
        o.q = best;
        if ({1'b0, draw} < eps_rate) begin
          o.expl = 1'b1;
          o.act  = (ract == ACT_NONE) ? ACT_LEFT : ract;
        end else begin
          o.act = b;
        end
      end
      FUNC_UPDATE: begin
        if (a != ACT_NONE) begin
          void'(greedy(ns, best));
          idx    = s*NUM_ACT + int'(a);
          cur    = longint'(q_mem[idx]);
          target = longint'(r) * (longint'(1) << Q_FRAC_BITS_DEF)
                 + round_frac(longint'(unit_clamp(gamma)) * longint'(best));
          nq     = cur + round_frac(longint'(unit_clamp(alpha)) * (target - cur));
          if (nq > longint'(Q_MAX)) o.q = Q_MAX;
          else if (nq < longint'(Q_MIN)) o.q = Q_MIN;
          else o.q = Q_W'(nq);
          q_mem[idx] = o.q;
        end
      end
      FUNC_DECAY: begin
        eps_rate = COEF_W'(longint'(eps_rate) * DECAY_NUM / DECAY_DEN);
      end
      default: ;
    endcase
    o.eps = eps_rate;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) q_mem[i] = '0;
      eps_rate = ONE_Q016;
      alpha    = LEARN_RATE_RST;
      gamma    = DISCOUNT_RST;
      awaited_outcomes.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (awaited_outcomes.size() == 0) begin
          if (err_count < 10)
            $display("[%0t] result %0d with nothing outstanding: act=%0d expl=%0d q=%0d eps=%0d",
                     $realtime, result_count, chosen_action, explored, q_value, epsilon_now);
          err_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (chosen_action !== want.act || explored !== want.expl ||
              q_value !== want.q || epsilon_now !== want.eps) begin
            if (err_count < 10)
              $display("[%0t] result %0d differs: exp act=%0d expl=%0d q=%0d eps=%0d, got act=%0d expl=%0d q=%0d eps=%0d",
                       $realtime, result_count, want.act, want.expl, want.q, want.eps,
                       chosen_action, explored, q_value, epsilon_now);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_outcomes.push_back(apply_transaction(func, int'(state_index), action_taken,
                                                     reward, int'(next_state_index),
                                                     explore_draw, random_action));
      if (cfg_write) begin
        if (cfg_index == CFG_LEARN_RATE) alpha = cfg_data;
        else gamma = cfg_data;
      end
    end
    mismatches <= err_count;
    pending    <= awaited_outcomes.size();
  end

endmodule

// File: verif/tabular_q_learning_agent_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tabular_q_learning_agent_test
// Drives the Q-learning agent with a directed opener (fresh table, explore
// boundary, saturation, ignored action, unused code, zero rates), then random
// transactions under four handshake modes and several coefficient settings,
// then a run of back-to-back decays. The checker beside the block predicts
// every result; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------

module tabular_q_learning_agent_test;
  import tqla_pkg::*;

  // Longest quiet stretch of a correct run is the post-reset table clear;
  // everything else is an update plus random stalls.
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         DRAIN_CYCLES   = 16;
  localparam int         PHASE_ITEMS    = 250;
  localparam int         SWEEP_DECAYS   = 200;   // decays back to back at the end
  localparam logic [1:0] FUNC_NOP       = 2'd3;  // unused code, no table or rate change

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic                      cfg_index;
  logic [COEF_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                func;
  logic [STATE_BITS_DEF-1:0] state_index;
  logic [1:0]                action_taken;
  logic signed [15:0]        reward;
  logic [STATE_BITS_DEF-1:0] next_state_index;
  logic [15:0]               explore_draw;
  logic [1:0]                random_action;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                chosen_action;
  logic                      explored;
  logic signed [Q_W-1:0]     q_value;
  logic [COEF_W-1:0]         epsilon_now;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stuck_cycles = 0;
  int n_choose = 0;
  int n_update = 0;
  int n_decay = 0;
  int n_nop = 0;
  int n_coef = 0;

  // a few states get most of the traffic so Q values build up
  logic [STATE_BITS_DEF-1:0] hot_states [8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tabular_q_learning_agent u_dut (.*);

  tabular_q_learning_agent_check u_check (.*);

  // receiver: stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // One transaction. Valid stays up with a fixed payload until taken; after
  // that an idle gap may follow. With no gap valid is left high so the next
  // call just swaps the payload.
  task automatic issue(input logic [1:0] fn, input logic [STATE_BITS_DEF-1:0] s,
                       input logic [1:0] a, input logic signed [15:0] r,
                       input logic [STATE_BITS_DEF-1:0] ns, input logic [15:0] draw,
                       input logic [1:0] ract);
    in_valid         <= 1'b1;
    func             <= fn;
    state_index      <= s;
    action_taken     <= a;
    reward           <= r;
    next_state_index <= ns;
    explore_draw     <= draw;
    random_action    <= ract;
    do @(posedge clk); while (!in_ready);
    case (fn)
      FUNC_CHOOSE: n_choose++;
      FUNC_UPDATE: n_update++;
      FUNC_DECAY:  n_decay++;
      default:     n_nop++;
    endcase
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // drop valid and wait for every predicted result to come back
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // both coefficients, back to back; only called with the block idle
  task automatic set_coefs(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] g);
    cfg_write <= 1'b1;
    cfg_index <= CFG_LEARN_RATE;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= CFG_DISCOUNT;
    cfg_data  <= g;
    @(posedge clk);
    cfg_write <= 1'b0;
    n_coef++;
  endtask

  function automatic logic [STATE_BITS_DEF-1:0] pick_state();
    if ($urandom_range(0, 99) < 70) return hot_states[$urandom_range(0, 7)];
    return STATE_BITS_DEF'($urandom_range(0, (1 << STATE_BITS_DEF) - 1));
  endfunction

  // Mostly updates and choices on hot states with small rewards; some full-range
  // rewards, ignored actions and the unused code as noise.
  task automatic random_item();
    int                 roll;
    logic [1:0]         fn;
    logic [1:0]         a;
    logic signed [15:0] r;
    logic [15:0]        draw;
    roll = $urandom_range(0, 99);
    if (roll < 35) fn = FUNC_CHOOSE;
    else if (roll < 80) fn = FUNC_UPDATE;
    else if (roll < 95) fn = FUNC_DECAY;
    else fn = FUNC_NOP;
    a = ($urandom_range(0, 99) < 5) ? ACT_NONE : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 70) r = 16'(int'($urandom_range(0, 20)) - 10);
    else r = 16'($urandom);
    // half the draws land near the top, where explore vs. exploit flips
    draw = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(58000, 65535));
    issue(fn, pick_state(), a, r, pick_state(), draw, 2'($urandom_range(0, 3)));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] g);
    set_coefs(a, g);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (PHASE_ITEMS) random_item();
    quiesce();
  endtask

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = CFG_LEARN_RATE;
    cfg_data         = '0;
    in_valid         = 1'b0;
    func             = FUNC_CHOOSE;
    state_index      = '0;
    action_taken     = ACT_LEFT;
    reward           = '0;
    next_state_index = '0;
    explore_draw     = '0;
    random_action    = ACT_LEFT;
    hot_states[0]    = '0;
    hot_states[7]    = '1;
    for (int i = 1; i < 7; i++)
      hot_states[i] = STATE_BITS_DEF'($urandom_range(1, (1 << STATE_BITS_DEF) - 2));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset coefficients; first transaction waits out the clear ---
    // rate is 1.0, so even the top draw explores; random action three folds to left
    issue(FUNC_CHOOSE, '0, ACT_LEFT, 16'sd0, '0, 16'hFFFF, ACT_NONE);
    issue(FUNC_CHOOSE, '1, ACT_RIGHT, 16'sd0, '1, 16'h0000, ACT_RIGHT);
    // extreme rewards at the state extremes
    issue(FUNC_UPDATE, '0, ACT_LEFT, 16'sh8000, '1, 16'h0000, ACT_LEFT);
    issue(FUNC_UPDATE, '1, ACT_RIGHT, 16'sh7FFF, '0, 16'h0000, ACT_LEFT);
    issue(FUNC_UPDATE, '0, ACT_STAY, 16'sd1, '1, 16'h0000, ACT_LEFT);
    // action three leaves the table alone
    issue(FUNC_UPDATE, '0, ACT_NONE, 16'sd123, '0, 16'h0000, ACT_LEFT);
    // unused code with every field at its top
    issue(FUNC_NOP, '1, ACT_NONE, -16'sd1, '1, 16'hFFFF, ACT_NONE);
    // one decay: 65536 -> 65503, then exploit, explore just below, exploit at the rate
    issue(FUNC_DECAY, '0, ACT_LEFT, 16'sd0, '0, 16'h0000, ACT_LEFT);
    issue(FUNC_CHOOSE, '0, ACT_LEFT, 16'sd0, '0, 16'hFFFF, ACT_STAY);
    issue(FUNC_CHOOSE, '0, ACT_LEFT, 16'sd0, '0, 16'd65502, ACT_STAY);
    issue(FUNC_CHOOSE, '0, ACT_LEFT, 16'sd0, '0, 16'd65503, ACT_STAY);
    issue(FUNC_CHOOSE, '1, ACT_LEFT, 16'sd0, '0, 16'hFFFF, ACT_LEFT);
    quiesce();

    // alpha above one (used as one), gamma exactly one: drive both saturation limits
    set_coefs(17'h1FFFF, ONE_Q016);
    issue(FUNC_UPDATE, 12'd7, ACT_LEFT, 16'sh7FFF, 12'd7, 16'h0000, ACT_LEFT);
    issue(FUNC_UPDATE, 12'd7, ACT_LEFT, 16'sh7FFF, 12'd7, 16'h0000, ACT_LEFT);
    issue(FUNC_UPDATE, 12'd9, ACT_LEFT, 16'sh8000, 12'd10, 16'h0000, ACT_LEFT);
    issue(FUNC_UPDATE, 12'd9, ACT_STAY, 16'sh8000, 12'd10, 16'h0000, ACT_LEFT);
    issue(FUNC_UPDATE, 12'd9, ACT_RIGHT, 16'sh8000, 12'd10, 16'h0000, ACT_LEFT);
    issue(FUNC_UPDATE, 12'd9, ACT_LEFT, 16'sh8000, 12'd9, 16'h0000, ACT_LEFT);
    // three-way tie at the minimum goes to left
    issue(FUNC_CHOOSE, 12'd9, ACT_LEFT, 16'sd0, '0, 16'hFFFF, ACT_LEFT);
    issue(FUNC_CHOOSE, 12'd7, ACT_LEFT, 16'sd0, '0, 16'hFFFF, ACT_LEFT);
    quiesce();

    // zero rates: a saturated entry stays put
    set_coefs('0, '0);
    issue(FUNC_UPDATE, 12'd7, ACT_LEFT, 16'sh8000, 12'd7, 16'h0000, ACT_LEFT);
    quiesce();

    // --- random phases, one handshake mode and coefficient pair each ---
    run_phase(0, 0, COEF_W'($urandom_range(1, 65535)), DISCOUNT_RST);
    run_phase(75, 0, ONE_Q016, 17'h1FFFF);
    run_phase(0, 75, COEF_W'($urandom), COEF_W'($urandom));
    run_phase(13, 13, 17'd1, 17'd65535);

    // --- decays back to back, then random traffic at the lowered rate ---
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    repeat (SWEEP_DECAYS)
      issue(FUNC_DECAY, pick_state(), 2'($urandom), 16'($urandom), pick_state(),
            16'($urandom), 2'($urandom));
    repeat (24) random_item();
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d choose, %0d update, %0d decay and %0d unused-code transactions",
             n_choose, n_update, n_decay, n_nop);
    $display("over %0d coefficient settings, four handshake modes and a run of decays",
             n_coef);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tqla_pkg.sv
rtl/core/tabular_q_learning_agent.sv
rtl/core/tqla_checker.sv
verif/tabular_q_learning_agent_check.sv
verif/tabular_q_learning_agent_test.sv
